/* src/scc_pkg.sv */
package scc_pkg;

    localparam int DEF_CACHE_ENTRIES = 64;
    localparam int SECTOR_W = 32;
    localparam int SLOT_W = 6;
    localparam int REQ_W = 2;
    localparam int KIND_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCESS    = 2'd0,
        KIND_WRITEBACK = 2'd1,
        KIND_NONE      = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_SWEEP,
        ST_EVICT,
        ST_FL_SCAN,
        ST_FL_EMIT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic load_vectors;
        logic do_hit;
        logic do_free_fill;
        logic sweep_step;
        logic do_evict;
        logic flush_step;
        logic flush_emit;
        logic flush_none;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic hit_any;
        logic free_any;
        logic ref_at_hand;
        logic dv_any;
        logic dv_at_idx;
        logic dv_last;
    } dp_status_t;

endpackage

/* src/scc_ram.sv */
module scc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/scc_ctrl.sv */
module scc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  scc_pkg::dp_status_t status,
    output scc_pkg::ctrl_cmd_t  cmd
);

    scc_pkg::state_t state_reg;
    scc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next = scc_pkg::ST_LOOKUP;
                end
            end
            scc_pkg::ST_LOOKUP:
            begin
                if (status.is_flush)
                begin
                    state_next = scc_pkg::ST_FL_SCAN;
                end
                else
                begin
                    cmd.load_vectors = 1'b1;
                    state_next = scc_pkg::ST_DECIDE;
                end
            end
            scc_pkg::ST_DECIDE:
            begin
                priority if (status.hit_any)
                begin
                    cmd.do_hit = 1'b1;
                    state_next = scc_pkg::ST_IDLE;
                end
                else if (status.free_any)
                begin
                    cmd.do_free_fill = 1'b1;
                    state_next = scc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = scc_pkg::ST_SWEEP;
                end
            end
            scc_pkg::ST_SWEEP:
            begin
                if (status.ref_at_hand)
                begin
                    cmd.sweep_step = 1'b1;
                end
                else
                begin
                    state_next = scc_pkg::ST_EVICT;
                end
            end
            scc_pkg::ST_EVICT:
            begin
                cmd.do_evict = 1'b1;
                state_next = scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_FL_SCAN:
            begin
                priority if (!status.dv_any)
                begin
                    cmd.flush_none = 1'b1;
                    state_next = scc_pkg::ST_IDLE;
                end
                else if (status.dv_at_idx)
                begin
                    state_next = scc_pkg::ST_FL_EMIT;
                end
                else
                begin
                    cmd.flush_step = 1'b1;
                end
            end
            scc_pkg::ST_FL_EMIT:
            begin
                cmd.flush_emit = 1'b1;
                if (status.dv_last)
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.flush_step = 1'b1;
                    state_next = scc_pkg::ST_FL_SCAN;
                end
            end
            default:
            begin
                state_next = scc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != scc_pkg::ST_IDLE);

endmodule

/* src/scc_datapath.sv */
module scc_datapath #(
    parameter int CACHE_ENTRIES = scc_pkg::DEF_CACHE_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [scc_pkg::REQ_W-1:0]    req_type,
    input  logic [scc_pkg::SECTOR_W-1:0] sector,
    input  scc_pkg::ctrl_cmd_t           cmd,
    output scc_pkg::dp_status_t          status,
    output logic                         result_valid,
    output logic [scc_pkg::KIND_W-1:0]   result_kind,
    output logic [scc_pkg::SLOT_W-1:0]   slot,
    output logic                         hit,
    output logic                         fill_needed,
    output logic                         victim_writeback,
    output logic [scc_pkg::SECTOR_W-1:0] writeback_sector,
    output logic                         last
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    logic [scc_pkg::REQ_W-1:0]    req_type_reg;
    logic [scc_pkg::SECTOR_W-1:0] sector_reg;
    logic [CACHE_ENTRIES-1:0]     valid_reg;
    logic [CACHE_ENTRIES-1:0]     dirty_reg;
    logic [CACHE_ENTRIES-1:0]     ref_reg;
    logic [CACHE_ENTRIES-1:0]     match_reg;
    logic [scc_pkg::SECTOR_W-1:0] cam_reg [CACHE_ENTRIES];
    logic [IDX_W-1:0]             hand_reg;
    logic [IDX_W-1:0]             idx_reg;

    logic                         result_valid_reg;
    logic [scc_pkg::KIND_W-1:0]   result_kind_reg;
    logic [scc_pkg::SLOT_W-1:0]   slot_reg;
    logic                         hit_reg;
    logic                         fill_needed_reg;
    logic                         victim_writeback_reg;
    logic [scc_pkg::SECTOR_W-1:0] writeback_sector_reg;
    logic                         last_reg;

    logic [IDX_W-1:0]             hit_idx;
    logic [IDX_W-1:0]             free_idx;
    logic [IDX_W-1:0]             hand_inc;
    logic [CACHE_ENTRIES-1:0]     dv;
    logic [CACHE_ENTRIES-1:0]     idx_onehot;
    logic                         is_write;
    logic                         is_clear;
    logic                         tag_we;
    logic [IDX_W-1:0]             tag_waddr;
    logic [IDX_W-1:0]             tag_raddr;
    logic [scc_pkg::SECTOR_W-1:0] tag_rdata;

    function automatic logic [IDX_W-1:0] first_set(input logic [CACHE_ENTRIES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    assign is_write = (req_type_reg == scc_pkg::REQ_WRITE);
    assign is_clear = (req_type_reg == scc_pkg::REQ_CLEAR);
    assign hit_idx = first_set(match_reg);
    assign free_idx = first_set(~valid_reg);
    assign hand_inc = (hand_reg == LAST_IDX) ? '0 : hand_reg + 1'b1;
    assign dv = valid_reg & dirty_reg;
    assign idx_onehot = {{(CACHE_ENTRIES-1){1'b0}}, 1'b1} << idx_reg;

    assign status.is_flush = req_type_reg[1];
    assign status.hit_any = |match_reg;
    assign status.free_any = ~&valid_reg;
    assign status.ref_at_hand = ref_reg[hand_reg];
    assign status.dv_any = |dv;
    assign status.dv_at_idx = dv[idx_reg];
    assign status.dv_last = ~|(dv & ~idx_onehot);

    // tag copy for write-back reads
    assign tag_we = cmd.do_free_fill | cmd.do_evict;
    assign tag_waddr = cmd.do_evict ? hand_reg : free_idx;
    assign tag_raddr = status.is_flush ? idx_reg : hand_reg;

    scc_ram #(
        .WIDTH (scc_pkg::SECTOR_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (sector_reg),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            sector_reg <= sector;
        end
        if (cmd.load_vectors)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                match_reg[i] <= valid_reg[i] && (cam_reg[i] == sector_reg);
            end
        end
        if (tag_we)
        begin
            cam_reg[tag_waddr] <= sector_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg <= '0;
            hand_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                idx_reg <= '0;
            end
            if (cmd.flush_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.do_hit)
            begin
                ref_reg[hit_idx] <= 1'b1;
                if (is_write)
                begin
                    dirty_reg[hit_idx] <= 1'b1;
                end
            end
            if (cmd.do_free_fill)
            begin
                valid_reg[free_idx] <= 1'b1;
                ref_reg[free_idx] <= 1'b1;
                dirty_reg[free_idx] <= is_write;
            end
            if (cmd.sweep_step)
            begin
                ref_reg[hand_reg] <= 1'b0;
                hand_reg <= hand_inc;
            end
            if (cmd.do_evict)
            begin
                valid_reg[hand_reg] <= 1'b1;
                ref_reg[hand_reg] <= 1'b1;
                dirty_reg[hand_reg] <= is_write;
                hand_reg <= hand_inc;
            end
            if (cmd.flush_emit && !(is_clear && status.dv_last))
            begin
                dirty_reg[idx_reg] <= 1'b0;
            end
            if (is_clear && (cmd.flush_none || (cmd.flush_emit && status.dv_last)))
            begin
                valid_reg <= '0;
                dirty_reg <= '0;
                ref_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.do_hit | cmd.do_free_fill | cmd.do_evict
                              | cmd.flush_emit | cmd.flush_none;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.do_hit)
        begin
            result_kind_reg <= scc_pkg::KIND_ACCESS;
            slot_reg <= scc_pkg::SLOT_W'(hit_idx);
            hit_reg <= 1'b1;
            fill_needed_reg <= 1'b0;
            victim_writeback_reg <= 1'b0;
            writeback_sector_reg <= '0;
            last_reg <= 1'b1;
        end
        else if (cmd.do_free_fill)
        begin
            result_kind_reg <= scc_pkg::KIND_ACCESS;
            slot_reg <= scc_pkg::SLOT_W'(free_idx);
            hit_reg <= 1'b0;
            fill_needed_reg <= 1'b1;
            victim_writeback_reg <= 1'b0;
            writeback_sector_reg <= '0;
            last_reg <= 1'b1;
        end
        else if (cmd.do_evict)
        begin
            result_kind_reg <= scc_pkg::KIND_ACCESS;
            slot_reg <= scc_pkg::SLOT_W'(hand_reg);
            hit_reg <= 1'b0;
            fill_needed_reg <= 1'b1;
            victim_writeback_reg <= dirty_reg[hand_reg];
            writeback_sector_reg <= dirty_reg[hand_reg] ? tag_rdata : '0;
            last_reg <= 1'b1;
        end
        else if (cmd.flush_emit)
        begin
            result_kind_reg <= scc_pkg::KIND_WRITEBACK;
            slot_reg <= scc_pkg::SLOT_W'(idx_reg);
            hit_reg <= 1'b0;
            fill_needed_reg <= 1'b0;
            victim_writeback_reg <= 1'b1;
            writeback_sector_reg <= tag_rdata;
            last_reg <= status.dv_last;
        end
        else if (cmd.flush_none)
        begin
            result_kind_reg <= scc_pkg::KIND_NONE;
            slot_reg <= '0;
            hit_reg <= 1'b0;
            fill_needed_reg <= 1'b0;
            victim_writeback_reg <= 1'b0;
            writeback_sector_reg <= '0;
            last_reg <= 1'b1;
        end
        else
        begin
            result_kind_reg <= result_kind_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind = result_kind_reg;
    assign slot = slot_reg;
    assign hit = hit_reg;
    assign fill_needed = fill_needed_reg;
    assign victim_writeback = victim_writeback_reg;
    assign writeback_sector = writeback_sector_reg;
    assign last = last_reg;

endmodule

/* src/sector_cache_clock_replacement_top.sv */
// hit or free slot: lookup, then decide, then the registered result
// full cache miss: the hand clears referenced slots one per cycle, then evicts its slot
// flush and clear: one write-back per dirty slot in slot order, else one empty result
// one request at a time; each result is a single-cycle strobe, the receiver cannot stall
// asynchronous active-low reset clears valid, dirty and reference bits and the clock hand
// tag storage is undefined after reset and needs no clearing pass
module sector_cache_clock_replacement_top #(
    parameter int CACHE_ENTRIES = scc_pkg::DEF_CACHE_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [scc_pkg::REQ_W-1:0]    req_type,
    input  logic [scc_pkg::SECTOR_W-1:0] sector,
    output logic                         result_valid,
    output logic [scc_pkg::KIND_W-1:0]   result_kind,
    output logic [scc_pkg::SLOT_W-1:0]   slot,
    output logic                         hit,
    output logic                         fill_needed,
    output logic                         victim_writeback,
    output logic [scc_pkg::SECTOR_W-1:0] writeback_sector,
    output logic                         last
);

    scc_pkg::ctrl_cmd_t  cmd;
    scc_pkg::dp_status_t status;

    scc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    scc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_type         (req_type),
        .sector           (sector),
        .cmd              (cmd),
        .status           (status),
        .result_valid     (result_valid),
        .result_kind      (result_kind),
        .slot             (slot),
        .hit              (hit),
        .fill_needed      (fill_needed),
        .victim_writeback (victim_writeback),
        .writeback_sector (writeback_sector),
        .last             (last)
    );

    a_access_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == scc_pkg::KIND_ACCESS) |-> last)
        else $error("access result without last");

    a_wb_sector_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !victim_writeback |-> (writeback_sector == '0))
        else $error("write-back sector set without write-back");

    a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == scc_pkg::KIND_NONE) |-> last && (slot == '0))
        else $error("empty flush result malformed");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !result_valid)
        else $error("accepted request did not raise busy");

    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && hit |-> !fill_needed && !victim_writeback)
        else $error("hit with fill or write-back");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int ENTRIES = scc_pkg::DEF_CACHE_ENTRIES;
    localparam int POOL_SIZE = 80;

    typedef struct {
        scc_pkg::result_kind_t        kind;
        logic [scc_pkg::SLOT_W-1:0]   slot;
        logic                         hit;
        logic                         fill;
        logic                         wb;
        logic [scc_pkg::SECTOR_W-1:0] wb_sector;
        logic                         last;
    } cache_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [scc_pkg::REQ_W-1:0]    req_type;
    logic [scc_pkg::SECTOR_W-1:0] sector;
    logic                         result_valid;
    logic [scc_pkg::KIND_W-1:0]   result_kind;
    logic [scc_pkg::SLOT_W-1:0]   slot;
    logic                         hit;
    logic                         fill_needed;
    logic                         victim_writeback;
    logic [scc_pkg::SECTOR_W-1:0] writeback_sector;
    logic                         last;

    // shadow copy of the cache directory
    bit                           line_valid [ENTRIES];
    bit                           line_dirty [ENTRIES];
    bit                           line_ref [ENTRIES];
    logic [scc_pkg::SECTOR_W-1:0] line_tag [ENTRIES];
    int                           hand_pos;

    cache_result_t                pending_results [$];
    logic [scc_pkg::SECTOR_W-1:0] sector_pool [POOL_SIZE];

    int error_count;
    int request_count;
    int hit_count;
    int eviction_count;
    int dirty_eviction_count;
    int flush_writeback_count;
    int result_count;

    sector_cache_clock_replacement_top #(
        .CACHE_ENTRIES(ENTRIES)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .sector           (sector),
        .result_valid     (result_valid),
        .result_kind      (result_kind),
        .slot             (slot),
        .hit              (hit),
        .fill_needed      (fill_needed),
        .victim_writeback (victim_writeback),
        .writeback_sector (writeback_sector),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int next_line(int s);
        return (s + 1 >= ENTRIES) ? 0 : s + 1;
    endfunction

    function automatic void push_result(scc_pkg::result_kind_t kind, int s, bit h, bit f,
                                        bit w, logic [scc_pkg::SECTOR_W-1:0] wsec, bit l);
        cache_result_t r;
        r.kind = kind;
        r.slot = s[scc_pkg::SLOT_W-1:0];
        r.hit = h;
        r.fill = f;
        r.wb = w;
        r.wb_sector = wsec;
        r.last = l;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_cache_request(scc_pkg::req_type_t rt,
                                                  logic [scc_pkg::SECTOR_W-1:0] sec);
        int s;
        int n;
        int last_idx;
        bit found_hit;
        bit found_free;
        bit wb;
        logic [scc_pkg::SECTOR_W-1:0] wsec;
        s = 0;
        n = 0;
        last_idx = 0;
        found_hit = 1'b0;
        found_free = 1'b0;
        wb = 1'b0;
        wsec = '0;
        request_count++;
        if (rt == scc_pkg::REQ_READ || rt == scc_pkg::REQ_WRITE)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!found_hit && line_valid[i] && line_tag[i] == sec)
                begin
                    s = i;
                    found_hit = 1'b1;
                end
            end
            if (found_hit)
            begin
                hit_count++;
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!found_free && !line_valid[i])
                    begin
                        s = i;
                        found_free = 1'b1;
                    end
                end
                if (!found_free)
                begin
                    eviction_count++;
                    if (hand_pos >= ENTRIES)
                        hand_pos = 0;
                    while (line_ref[hand_pos])
                    begin
                        line_ref[hand_pos] = 1'b0;
                        hand_pos = next_line(hand_pos);
                    end
                    s = hand_pos;
                    if (line_dirty[s])
                    begin
                        wb = 1'b1;
                        wsec = line_tag[s];
                        dirty_eviction_count++;
                    end
                    hand_pos = next_line(hand_pos);
                end
                line_tag[s] = sec;
                line_valid[s] = 1'b1;
                line_dirty[s] = 1'b0;
            end
            line_ref[s] = 1'b1;
            if (rt == scc_pkg::REQ_WRITE)
                line_dirty[s] = 1'b1;
            push_result(scc_pkg::KIND_ACCESS, s, found_hit, !found_hit, wb, wsec, 1'b1);
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (line_valid[i] && line_dirty[i])
                begin
                    n++;
                    last_idx = i;
                end
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (line_valid[i] && line_dirty[i])
                begin
                    push_result(scc_pkg::KIND_WRITEBACK, i, 1'b0, 1'b0, 1'b1, line_tag[i],
                                i == last_idx);
                    line_dirty[i] = 1'b0;
                    flush_writeback_count++;
                end
                if (rt == scc_pkg::REQ_CLEAR)
                begin
                    line_valid[i] = 1'b0;
                    line_dirty[i] = 1'b0;
                    line_ref[i] = 1'b0;
                end
            end
            if (n == 0)
                push_result(scc_pkg::KIND_NONE, 0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
        end
    endfunction

    always @(posedge clk)
    begin
        cache_result_t exp_r;
        if (rst_n && result_valid)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d", result_kind, slot);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_kind !== exp_r.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", exp_r.kind, result_kind);
                    error_count++;
                end
                if (slot !== exp_r.slot)
                begin
                    $error("slot: expected %0d, actual %0d", exp_r.slot, slot);
                    error_count++;
                end
                if (hit !== exp_r.hit)
                begin
                    $error("hit: expected %0d, actual %0d", exp_r.hit, hit);
                    error_count++;
                end
                if (fill_needed !== exp_r.fill)
                begin
                    $error("fill_needed: expected %0d, actual %0d", exp_r.fill, fill_needed);
                    error_count++;
                end
                if (victim_writeback !== exp_r.wb)
                begin
                    $error("victim_writeback: expected %0d, actual %0d",
                           exp_r.wb, victim_writeback);
                    error_count++;
                end
                if (writeback_sector !== exp_r.wb_sector)
                begin
                    $error("writeback_sector: expected %h, actual %h",
                           exp_r.wb_sector, writeback_sector);
                    error_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_r.last, last);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(scc_pkg::req_type_t rt, logic [scc_pkg::SECTOR_W-1:0] sec);
        int gap;
        gap = $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= rt;
        sector <= sec;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_cache_request(rt, sec);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [scc_pkg::SECTOR_W-1:0] pick_sector(int pool_hi);
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return sector_pool[$urandom_range(0, pool_hi)];
    endfunction

    function automatic scc_pkg::req_type_t pick_access();
        return ($urandom_range(0, 1) == 0) ? scc_pkg::REQ_READ : scc_pkg::REQ_WRITE;
    endfunction

    task automatic test_basic_access();
        send_request(scc_pkg::REQ_READ, '0);
        send_request(scc_pkg::REQ_WRITE, '1);
        send_request(scc_pkg::REQ_READ, '0);
        send_request(scc_pkg::REQ_WRITE, '0);
        send_request(scc_pkg::REQ_READ, '1);
        send_request(scc_pkg::REQ_WRITE, 32'h5555_AAAA);
        send_request(scc_pkg::REQ_READ, 32'hAAAA_5555);
    endtask

    task automatic test_flush_clear();
        send_request(scc_pkg::REQ_FLUSH, '1);
        send_request(scc_pkg::REQ_FLUSH, '0);
        send_request(scc_pkg::REQ_WRITE, 32'h0000_0001);
        send_request(scc_pkg::REQ_CLEAR, 32'h8000_0000);
        send_request(scc_pkg::REQ_CLEAR, '0);
        send_request(scc_pkg::REQ_FLUSH, $urandom);
        send_request(scc_pkg::REQ_READ, 32'h0000_0001);
        send_request(scc_pkg::REQ_WRITE, 32'h8000_0000);
        send_request(scc_pkg::REQ_FLUSH, '0);
        send_request(scc_pkg::REQ_CLEAR, '1);
    endtask

    // fill every slot, then force sweeps and dirty evictions
    task automatic test_clock_eviction();
        for (int i = 0; i < ENTRIES; i++)
            send_request(pick_access(), sector_pool[i]);
        wait_drained();
        for (int i = 0; i < 40; i++)
            send_request(pick_access(), pick_sector(POOL_SIZE - 1));
        send_request(scc_pkg::REQ_FLUSH, $urandom);
    endtask

    task automatic test_random_traffic();
        int r;
        for (int i = 0; i < 160; i++)
        begin
            if (i == 80)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 4)
                send_request(scc_pkg::REQ_FLUSH, $urandom);
            else if (r < 6)
                send_request(scc_pkg::REQ_CLEAR, $urandom);
            else
                send_request(pick_access(), pick_sector(POOL_SIZE - 1));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = scc_pkg::REQ_READ;
        sector = '0;
        error_count = 0;
        request_count = 0;
        hit_count = 0;
        eviction_count = 0;
        dirty_eviction_count = 0;
        flush_writeback_count = 0;
        result_count = 0;
        hand_pos = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_ref[i] = 1'b0;
            line_tag[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            sector_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_access();
        test_flush_clear();
        test_clock_eviction();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d requests, %0d results: %0d hits, %0d clock evictions",
                 request_count, result_count, hit_count, eviction_count);
        $display("%0d evictions wrote back a dirty sector, flush and clear wrote back %0d slots",
                 dirty_eviction_count, flush_writeback_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout waiting for results");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
